### hdl/ogtr_pkg.sv
// Shared constants, codes and types of the outlined glyph text renderer.
package ogtr_pkg;

    localparam int FONT_WIDTH       = 8;
    localparam int FONT_HEIGHT_DEF  = 16;
    localparam int Q_DEPTH          = 4;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 16;

    typedef enum logic [1:0] {
        CMD_ROW     = 2'd0,
        CMD_NEWLINE = 2'd1,
        CMD_START   = 2'd2
    } t_cmd;

    localparam logic [CFG_ADDR_W-1:0] REG_FG_COLOR      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_LEFT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_TOP      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_WIDTH    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_HEIGHT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CLIP_ENABLE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_WIDTH  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_HEIGHT = 3'd7;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [7:0]         fg_mask;
        logic [7:0]         outline_mask;
        logic [8:0]         draw_color;
        logic [8:0]         outline_color;
        logic               glyph_done;
        logic               area_full;
    } t_result;

endpackage

### hdl/ogtr_ifs.sv
// Handshake interfaces of the renderer: command input, result output, config writes.
interface ogtr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] row_bits;

    modport source (output valid, cmd, row_bits, input ready);
    modport sink   (input valid, cmd, row_bits, output ready);
endinterface

interface ogtr_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]         fg_mask;
    logic [7:0]         outline_mask;
    logic [8:0]         draw_color;
    logic [8:0]         outline_color;
    logic               glyph_done;
    logic               area_full;

    modport source (output valid, pixel_x, pixel_y, fg_mask, outline_mask, draw_color,
                    outline_color, glyph_done, area_full, input ready);
    modport sink   (input valid, pixel_x, pixel_y, fg_mask, outline_mask, draw_color,
                    outline_color, glyph_done, area_full, output ready);
endinterface

interface ogtr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ogtr_pkg::CFG_ADDR_W-1:0]     addr;
    logic [ogtr_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### hdl/outlined_glyph_text_renderer.sv
// Outlined glyph text renderer: row masks, clipping, cursor and a small result queue.
//
//  channel  dir  payload                                        handshake
//  i_cmd    in   cmd, row_bits                                  valid/ready
//  o_res    out  pixel_x/y, fg/outline mask, colors, done, full valid/ready
//  i_cfg    in   addr (register index), data                    valid/ready (always ready)
//
// One item is taken per cycle while i_cmd.ready is high; its results are written into the
// result queue at the accepting edge and leave on o_res in queue order (a row comes out one row late).
// The last row of a glyph yields two results, which o_res hands out one after the other.
// i_cmd.ready drops while the four-entry result queue has fewer than two free slots.
// Reset (synchronous, active low) restores the register defaults, clears the cursor and empties the queue.
module outlined_glyph_text_renderer #(
    parameter int FONT_HEIGHT = ogtr_pkg::FONT_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ogtr_cmd_if.sink         i_cmd,
    ogtr_res_if.source       o_res,
    ogtr_cfg_if.sink         i_cfg
);

    localparam int ROW_W = (FONT_HEIGHT > 2) ? $clog2(FONT_HEIGHT) : 1;
    localparam int QP_W  = $clog2(ogtr_pkg::Q_DEPTH);
    localparam int QC_W  = QP_W + 1;

    // configuration
    logic [8:0]         r_fg_color;
    logic [15:0]        r_area_left;
    logic [15:0]        r_area_top;
    logic [14:0]        r_area_width;
    logic [14:0]        r_area_height;
    logic               r_clip_enable;
    logic [14:0]        r_canvas_width;
    logic [14:0]        r_canvas_height;

    // cursor and glyph state
    logic [15:0]        r_cursor_x, n_cursor_x;
    logic [15:0]        r_cursor_y, n_cursor_y;
    logic [ROW_W-1:0]   r_row_count, n_row_count;
    logic [7:0]         r_above_row, n_above_row;
    logic [7:0]         r_held_row, n_held_row;
    logic               r_full, n_full;

    // result queue
    ogtr_pkg::t_result  r_q [ogtr_pkg::Q_DEPTH];
    logic [QP_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QC_W-1:0]    r_count;

    logic               in_fire, out_fire;
    logic               push0, push1;
    ogtr_pkg::t_result  res0, res1;

    logic [16:0]        cx17, cy17, y_mid, y_last, lf_ny;
    logic [17:0]        lf_lim, adv_nx, adv_lim;
    logic               lf_full, adv_wrap;
    logic [QC_W-1:0]    push_n;

    function automatic ogtr_pkg::t_result f_emit(
        input logic [7:0]  row,
        input logic [7:0]  above,
        input logic [7:0]  below,
        input logic [16:0] x,
        input logic [16:0] y,
        input logic        done,
        input logic        full,
        input logic        clip,
        input logic [14:0] cw,
        input logic [14:0] ch,
        input logic [8:0]  color
    );
        ogtr_pkg::t_result r;
        logic [7:0]  keep;
        logic [7:0]  ol;
        logic [16:0] px;
        logic        y_ok;
        ol   = (above | below | (row << 1) | (row >> 1)) & ~row;
        y_ok = !y[16] && ($signed(y) < $signed({2'b00, ch}));
        for (int i = 0; i < ogtr_pkg::FONT_WIDTH; i++) begin
            px = x + 17'(i);
            keep[ogtr_pkg::FONT_WIDTH-1-i] = y_ok && !px[16]
                                           && ($signed(px) < $signed({2'b00, cw}));
        end
        if (!clip) begin
            keep = 8'hFF;
        end
        r.pixel_x       = x[15:0];
        r.pixel_y       = y[15:0];
        r.fg_mask       = row & keep;
        r.outline_mask  = ol & keep;
        r.draw_color    = color;
        r.outline_color = ~color;
        r.glyph_done    = done;
        r.area_full     = full;
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_count <= QC_W'(ogtr_pkg::Q_DEPTH - 2));
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign out_fire    = o_res.valid && o_res.ready;

    // cursor arithmetic, all in widened signed form
    always_comb begin
        cx17     = {r_cursor_x[15], r_cursor_x};
        cy17     = {r_cursor_y[15], r_cursor_y};
        y_mid    = cy17 + {{(17-ROW_W){1'b0}}, r_row_count} - 17'd1;
        y_last   = cy17 + 17'(FONT_HEIGHT - 1);
        lf_ny    = cy17 + 17'(FONT_HEIGHT);
        lf_lim   = {{2{r_area_top[15]}}, r_area_top} + {3'b000, r_area_height};
        lf_full  = ($signed(lf_ny) > 17'sd32767)
                || ($signed({lf_ny[16], lf_ny}) >= $signed(lf_lim));
        adv_nx   = {{2{r_cursor_x[15]}}, r_cursor_x} + 18'd8;
        adv_lim  = {{2{r_area_left[15]}}, r_area_left} + {3'b000, r_area_width};
        adv_wrap = ($signed(adv_nx) > 18'sd32767) || ($signed(adv_nx) >= $signed(adv_lim));
    end

    always_comb begin
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_row_count = r_row_count;
        n_above_row = r_above_row;
        n_held_row  = r_held_row;
        n_full      = r_full;
        push0       = 1'b0;
        push1       = 1'b0;
        res0 = f_emit(r_held_row, r_above_row, i_cmd.row_bits, cx17, y_mid, 1'b0, 1'b0,
                      r_clip_enable, r_canvas_width, r_canvas_height, r_fg_color);
        res1 = f_emit(i_cmd.row_bits, r_held_row, 8'h00, cx17, y_last, 1'b1,
                      adv_wrap && lf_full,
                      r_clip_enable, r_canvas_width, r_canvas_height, r_fg_color);
        if (in_fire) begin
            case (i_cmd.cmd)
                ogtr_pkg::CMD_START: begin
                    n_cursor_x  = r_area_left;
                    n_cursor_y  = r_area_top;
                    n_full      = 1'b0;
                    n_row_count = '0;
                    n_above_row = '0;
                    n_held_row  = '0;
                end
                ogtr_pkg::CMD_NEWLINE: begin
                    if (!r_full) begin
                        n_row_count = '0;
                        n_above_row = '0;
                        n_held_row  = '0;
                        n_cursor_x  = r_area_left;
                        if (lf_full) begin
                            n_full = 1'b1;
                        end else begin
                            n_cursor_y = lf_ny[15:0];
                        end
                    end
                end
                ogtr_pkg::CMD_ROW: begin
                    if (!r_full) begin
                        if (r_row_count == '0) begin
                            n_above_row = '0;
                            n_held_row  = i_cmd.row_bits;
                            n_row_count = ROW_W'(1);
                        end else if (r_row_count == ROW_W'(FONT_HEIGHT - 1)) begin
                            push0       = 1'b1;
                            push1       = 1'b1;
                            n_row_count = '0;
                            n_above_row = '0;
                            n_held_row  = '0;
                            if (adv_wrap) begin
                                n_cursor_x = r_area_left;
                                if (lf_full) begin
                                    n_full = 1'b1;
                                end else begin
                                    n_cursor_y = lf_ny[15:0];
                                end
                            end else begin
                                n_cursor_x = adv_nx[15:0];
                            end
                        end else begin
                            push0       = 1'b1;
                            n_above_row = r_held_row;
                            n_held_row  = i_cmd.row_bits;
                            n_row_count = r_row_count + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        push_n = {{(QC_W-1){1'b0}}, push0} + {{(QC_W-1){1'b0}}, push1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color      <= 9'h1FF;
            r_area_left     <= '0;
            r_area_top      <= '0;
            r_area_width    <= 15'h7FFF;
            r_area_height   <= 15'h7FFF;
            r_clip_enable   <= 1'b1;
            r_canvas_width  <= 15'd320;
            r_canvas_height <= 15'd240;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                ogtr_pkg::REG_FG_COLOR:      r_fg_color      <= i_cfg.data[8:0];
                ogtr_pkg::REG_AREA_LEFT:     r_area_left     <= i_cfg.data;
                ogtr_pkg::REG_AREA_TOP:      r_area_top      <= i_cfg.data;
                ogtr_pkg::REG_AREA_WIDTH:    r_area_width    <= i_cfg.data[14:0];
                ogtr_pkg::REG_AREA_HEIGHT:   r_area_height   <= i_cfg.data[14:0];
                ogtr_pkg::REG_CLIP_ENABLE:   r_clip_enable   <= i_cfg.data[0];
                ogtr_pkg::REG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg.data[14:0];
                ogtr_pkg::REG_CANVAS_HEIGHT: r_canvas_height <= i_cfg.data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_row_count <= '0;
            r_above_row <= '0;
            r_held_row  <= '0;
            r_full      <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_row_count <= n_row_count;
            r_above_row <= n_above_row;
            r_held_row  <= n_held_row;
            r_full      <= n_full;
            r_wr_ptr    <= r_wr_ptr + push_n[QP_W-1:0];
            r_rd_ptr    <= r_rd_ptr + QP_W'(out_fire);
            r_count     <= r_count + push_n - QC_W'(out_fire);
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push1) begin
            r_q[r_wr_ptr + 1'b1] <= res1;
        end
    end

    assign o_res.valid         = (r_count != '0);
    assign o_res.pixel_x       = r_q[r_rd_ptr].pixel_x;
    assign o_res.pixel_y       = r_q[r_rd_ptr].pixel_y;
    assign o_res.fg_mask       = r_q[r_rd_ptr].fg_mask;
    assign o_res.outline_mask  = r_q[r_rd_ptr].outline_mask;
    assign o_res.draw_color    = r_q[r_rd_ptr].draw_color;
    assign o_res.outline_color = r_q[r_rd_ptr].outline_color;
    assign o_res.glyph_done    = r_q[r_rd_ptr].glyph_done;
    assign o_res.area_full     = r_q[r_rd_ptr].area_full;

endmodule
